/* rtl/core/idaf_pkg.sv */
`default_nettype none

package idaf_pkg;

  localparam int ID_SPACE_DEF = 256;

  localparam int LANES  = 16;
  localparam int LANE_W = 4;

  localparam int KIND_W      = 2;
  localparam int ID_IN_W     = 8;
  localparam int ID_OUT_W    = 8;
  localparam int CNT_OUT_W   = 9;
  localparam int S_DATA_W    = 8;
  localparam int M_DATA_W    = 24;
  localparam int M_PAD_W     = M_DATA_W - ID_OUT_W - 1 - CNT_OUT_W - 1;

  localparam logic [KIND_W-1:0] K_REQ   = 2'd0;
  localparam logic [KIND_W-1:0] K_REG   = 2'd1;
  localparam logic [KIND_W-1:0] K_UNREG = 2'd2;
  localparam logic [KIND_W-1:0] K_QUERY = 2'd3;

  typedef struct packed {
    logic clr_wr;
    logic cap_in;
    logic rd_id;
    logic apply;
    logic scan_step;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_req;
    logic in_ok;
    logic scan_done;
    logic out_free;
  } st_t;

  function automatic logic [LANE_W-1:0] first_set(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] idx;
    idx = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LANE_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/idaf_ram.sv */
`default_nettype none

module idaf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/idaf_ctrl.sv */
`default_nettype none

module idaf_ctrl import idaf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output cmd_t      cmd,
  input  wire st_t  st
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          if (st.in_req) begin
            state_next = S_SCAN;
          end else if (st.in_ok) begin
            state_next = S_RD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_RD: begin
        cmd.rd_id  = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_RESP;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/idaf_dp.sv */
`default_nettype none

module idaf_dp import idaf_pkg::*; #(
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output st_t                        st,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic [ID_IN_W-1:0]    in_id,
  input  wire logic                  m_tready,
  output logic                       out_valid,
  output logic      [ID_OUT_W-1:0]   assigned_id,
  output logic                       is_registered,
  output logic      [CNT_OUT_W-1:0]  registered_count,
  output logic                       exhausted
);

  localparam int ROWS  = (ID_SPACE + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW    = ROW_W + LANE_W;
  localparam int CNT_W = $clog2(ID_SPACE + 1);
  localparam int MEM_W = 2 * LANES;
  localparam int CMP_W = (IW + 1 > ID_IN_W + 1) ? IW + 1 : ID_IN_W + 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
  localparam logic [IW:0]      SPACE    = (IW + 1)'(ID_SPACE);

  logic [KIND_W-1:0] kind;
  logic [IW-1:0]     id;
  logic              id_ok;
  logic [CNT_W-1:0]  count;
  logic [IW-1:0]     ctr;
  logic [ROW_W-1:0]  clr_row;

  logic [ROW_W-1:0]  scan_ptr;
  logic              scan_end;
  logic              chk_vld;
  logic [ROW_W-1:0]  chk_row;
  logic              found;
  logic              sel_rel;
  logic [ROW_W-1:0]  sel_row;
  logic [LANE_W-1:0] sel_lane;
  logic [MEM_W-1:0]  sel_word;

  logic [IW-1:0]     res_assigned;
  logic              res_isreg;
  logic              res_exh;

  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic [MEM_W-1:0]  rd_data;

  logic [LANES-1:0]  used_w;
  logic [LANES-1:0]  rel_w;
  logic [LANES-1:0]  free_v;
  logic [IW:0]       c_start;
  logic              rel_hit;
  logic              free_hit;
  logic [LANE_W-1:0] id_lane;
  logic [ROW_W-1:0]  id_row;
  logic [LANES-1:0]  id_oh;
  logic [LANES-1:0]  sel_oh;
  logic              id_used;
  logic              sel_used;

  idaf_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ROWS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign used_w   = rd_data[LANES-1:0];
  assign rel_w    = rd_data[MEM_W-1:LANES];
  assign id_lane  = id[LANE_W-1:0];
  assign id_row   = id[IW-1:LANE_W];
  assign id_oh    = LANES'(1) << id_lane;
  assign sel_oh   = LANES'(1) << sel_lane;
  assign id_used  = used_w[id_lane];
  assign sel_used = sel_word[sel_lane];
  assign c_start  = {1'b0, ctr} + (IW + 1)'(1);

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      free_v[b] = !used_w[b] && ({1'b0, chk_row, LANE_W'(b)} >= c_start)
                  && ({1'b0, chk_row, LANE_W'(b)} < SPACE);
    end
  end

  assign rel_hit  = |rel_w;
  assign free_hit = |free_v;

  assign st.clr_last  = (clr_row == LAST_ROW);
  assign st.in_req    = (in_kind == K_REQ);
  assign st.in_ok     = (CMP_W'(in_id) < CMP_W'(ID_SPACE));
  assign st.scan_done = chk_vld && (rel_hit || chk_row == LAST_ROW);
  assign st.out_free  = !out_valid || m_tready;

  assign rd_en   = cmd.rd_id || (cmd.scan_step && !scan_end);
  assign rd_addr = cmd.rd_id ? id_row : scan_ptr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = id_row;
    wr_data = rd_data;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_row;
      wr_data = '0;
    end else if (cmd.apply && kind == K_REG) begin
      wr_en   = 1'b1;
      wr_data = {rel_w & ~id_oh, used_w | id_oh};
    end else if (cmd.apply && kind == K_UNREG) begin
      wr_en   = 1'b1;
      wr_data = {rel_w | id_oh, used_w & ~id_oh};
    end else if (cmd.commit && found) begin
      wr_en   = 1'b1;
      wr_addr = sel_row;
      wr_data = {sel_word[MEM_W-1:LANES] & ~sel_oh, sel_word[LANES-1:0] | sel_oh};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row <= '0;
    end else if (cmd.clr_wr && clr_row != LAST_ROW) begin
      clr_row <= clr_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ctr   <= '0;
    end else if (cmd.apply) begin
      if (kind == K_REG && !id_used) begin
        count <= count + CNT_W'(1);
      end else if (kind == K_UNREG && id_used) begin
        count <= count - CNT_W'(1);
      end
    end else if (cmd.commit && found) begin
      if (!sel_used) begin
        count <= count + CNT_W'(1);
      end
      if (!sel_rel) begin
        ctr <= {sel_row, sel_lane};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      kind         <= in_kind;
      id           <= IW'(in_id);
      id_ok        <= st.in_ok;
      scan_ptr     <= '0;
      scan_end     <= 1'b0;
      chk_vld      <= 1'b0;
      found        <= 1'b0;
      sel_rel      <= 1'b0;
      res_assigned <= '0;
      res_isreg    <= 1'b0;
      res_exh      <= 1'b0;
    end
    if (cmd.scan_step) begin
      chk_vld <= !scan_end;
      chk_row <= scan_ptr;
      if (!scan_end) begin
        if (scan_ptr == LAST_ROW) begin
          scan_end <= 1'b1;
        end else begin
          scan_ptr <= scan_ptr + ROW_W'(1);
        end
      end
      if (chk_vld) begin
        if (rel_hit && !sel_rel) begin
          found    <= 1'b1;
          sel_rel  <= 1'b1;
          sel_row  <= chk_row;
          sel_word <= rd_data;
          sel_lane <= first_set(rel_w);
        end else if (free_hit && !found) begin
          found    <= 1'b1;
          sel_row  <= chk_row;
          sel_word <= rd_data;
          sel_lane <= first_set(free_v);
        end
      end
    end
    if (cmd.apply && kind == K_QUERY && id_ok) begin
      res_isreg <= id_used;
    end
    if (cmd.commit) begin
      if (found) begin
        res_assigned <= {sel_row, sel_lane};
      end else begin
        res_exh <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      assigned_id      <= ID_OUT_W'(res_assigned);
      is_registered    <= res_isreg;
      registered_count <= CNT_OUT_W'(count);
      exhausted        <= res_exh;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/id_allocator_free_list.sv */
// ID allocator with a free list over ID_SPACE IDs.
// Input channel s_*: one word per operation. s_tuser carries the kind
// (request, register, unregister, query), s_tdata the ID operand.
// Output channel m_*: exactly one word per input word, in order, with the
// handed-out ID, the query answer, the registered count after the
// operation and the exhausted flag.
// The used and released marks live in one RAM of ceil(ID_SPACE/16) rows,
// 16 IDs per row. For an ID below ID_SPACE, register and unregister do one
// read-modify-write and query one read. A request scans the rows in order,
// one per cycle, stopping at the first row with a released ID. The next
// word is taken only after the result is loaded into the output register.
// After rst the RAM is cleared, one row per cycle, with s_tready low until
// every row is cleared.
// A finished result waits in the output register while m_tready is low;
// the next word is accepted meanwhile, and its result is held until the
// output register frees up.
`default_nettype none

module id_allocator_free_list import idaf_pkg::*; #(
  parameter int ID_SPACE = ID_SPACE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] id_value
  input  wire logic [KIND_W-1:0]   s_tuser,   // [1:0] kind
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic      [M_DATA_W-1:0] m_tdata    // [7:0] assigned_id, [8] is_registered,
                                              // [17:9] registered_count, [18] exhausted
);

  cmd_t                 cmd;
  st_t                  st;
  logic [ID_OUT_W-1:0]  assigned_id;
  logic                 is_registered;
  logic [CNT_OUT_W-1:0] registered_count;
  logic                 exhausted;

  idaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  idaf_dp #(
    .ID_SPACE (ID_SPACE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .in_kind          (s_tuser),
    .in_id            (s_tdata[ID_IN_W-1:0]),
    .m_tready         (m_tready),
    .out_valid        (m_tvalid),
    .assigned_id      (assigned_id),
    .is_registered    (is_registered),
    .registered_count (registered_count),
    .exhausted        (exhausted)
  );

  assign m_tdata = {M_PAD_W'(0), exhausted, registered_count, is_registered, assigned_id};

endmodule

`default_nettype wire
